/* hdl/assert_macros.svh */
// Assertion macros shared by the vector ALU RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define V3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("vector alu assertion failed");

// Checked on every clock edge, reset included.
`define V3_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("vector alu assertion failed");

`endif

/* hdl/v3alu_pkg.sv */
// Operation codes and fixed pipeline constants of the vector ALU.
package v3alu_pkg;

  typedef enum logic [3:0] {
    FN_ADD     = 4'd0,
    FN_SUB     = 4'd1,
    FN_SCALE   = 4'd2,
    FN_DIV     = 4'd3,
    FN_LEN     = 4'd4,
    FN_LENSQ   = 4'd5,
    FN_NORM    = 4'd6,
    FN_DOT     = 4'd7,
    FN_DIST    = 4'd8,
    FN_CROSS   = 4'd9,
    FN_REFLECT = 4'd10,
    FN_LERP    = 4'd11
  } func_e;

  localparam int unsigned LANES    = 3;
  localparam int unsigned MUL_LAT  = 2;
  // operand register, multiplier, combine register
  localparam int unsigned LANE_LAT = MUL_LAT + 2;

endpackage

/* hdl/vec3_fixed_point_alu_core.sv */
// Top level of the three-component fixed-point vector ALU.
//
// Signed fixed-point vector unit (WORD_BITS-bit words, FRAC_BITS fraction bits,
// Q16.16 by default). Each input beat carries an operation code in tuser and
// vectors a, b plus a scalar in tdata; each output beat carries the result vector,
// the scalar result and the div_zero / saturated flags. The unit is fully
// pipelined: it takes one beat every cycle while the output is taken, and
// most of its depth lies in the floor square root, WORD_BITS+1 stages,
// followed by the divider, WORD_BITS+FRAC_BITS stages; every beat passes
// both so order is kept. Three lanes handle x, y and z side by side and a merge
// stage sums them for dot products and lengths. When the output is not taken
// the whole pipeline holds, bubbles included, and the input is stalled with it.
`include "assert_macros.svh"

module vec3_fixed_point_alu_core import v3alu_pkg::*; #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // ax, ay, az, bx, by, bz, scalar_in (lowest first), zero padded to bytes
  input  logic [((7*WORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // func
  input  logic [3:0]                              s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // rx, ry, rz, scalar_out (lowest first), zero padded to bytes
  output logic [((4*WORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
  // div_zero, saturated (lowest first)
  output logic [1:0]                              m_axis_tuser
);

  localparam int unsigned W      = WORD_BITS;
  localparam int unsigned F      = FRAC_BITS;
  localparam int unsigned SW     = 2 * W + 6;
  localparam int unsigned SQ_LAT = W + 1;
  localparam int unsigned DV_LAT = W + F;
  localparam int unsigned OUT_DW = ((4 * W + 7) / 8) * 8;

  typedef struct packed {
    func_e              func;
    logic [2:0][W-1:0]  a;
    logic [2:0][W-1:0]  b;
    logic [W-1:0]       s;
    logic [2:0][W-1:0]  r;
    logic [W-1:0]       sc;
    logic               dz;
    logic               sat;
    logic [2:0]         neg;
    logic [W:0]         dt2;
    logic [2*W+1:0]     rad;
  } item_t;

  // clamp to the word range; top bit of the result is the clamp flag
  function automatic logic [W:0] sat_f(input logic [SW-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[SW-1:W-1];
    all_zero = ~|v[SW-1:W-1];
    if (all_one || all_zero) begin
      return {1'b0, v[W-1:0]};
    end else if (v[SW-1]) begin
      return {1'b1, 1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(W-1){1'b1}}};
    end
  endfunction

  function automatic logic [W-1:0] mag_f(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  logic en;

  // input stage
  item_t in_d, in_q;
  logic  in_vld_q;

  // lane stages
  item_t                 lp_q [LANE_LAT];
  logic [LANE_LAT-1:0]   lp_vld_q;
  logic signed [2*W+2:0] lane_v [LANES];

  // merge stage
  item_t                 mg_q;
  logic                  mg_vld_q;
  logic signed [2*W+4:0] sum_q;
  logic signed [2*W+2:0] vm_q [LANES];

  // early results
  item_t                 ev_d, ev_q;
  logic                  ev_vld_q;
  logic [W:0]            sum_s;
  logic [W:0]            rv;
  logic signed [SW-1:0]  ea, eb;

  // reflect multiply
  item_t                 rp_q [MUL_LAT];
  logic [MUL_LAT-1:0]    rp_vld_q;
  logic signed [2*W:0]   rp_p [LANES];
  item_t                 rf_d, rf_q;
  logic                  rf_vld_q;
  logic [W:0]            rv_rf;

  // square root
  item_t                 sq_q [SQ_LAT];
  logic [SQ_LAT-1:0]     sq_vld_q;
  logic [W:0]            root;
  item_t                 dp_d, dp_q;
  logic                  dp_vld_q;
  logic [W:0]            root_s;
  logic [W+F-1:0]        num_d [LANES];
  logic [W+F-1:0]        num_q [LANES];
  logic [W-1:0]          den_d, den_q;

  // divide
  item_t                 dv_q [DV_LAT];
  logic [DV_LAT-1:0]     dv_vld_q;
  logic [W+F-1:0]        quo [LANES];
  item_t                 out_d, out_q;
  logic                  out_vld_q;
  logic signed [SW-1:0]  qe;
  logic [W:0]            rv_q;

  assign en            = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    in_d      = '0;
    in_d.func = func_e'(s_axis_tuser);
    for (int i = 0; i < 3; i++) begin
      in_d.a[i] = s_axis_tdata[i*W +: W];
      in_d.b[i] = s_axis_tdata[(i+3)*W +: W];
    end
    in_d.s = s_axis_tdata[6*W +: W];
  end

  // valid chain; all stages advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      lp_vld_q  <= '0;
      mg_vld_q  <= 1'b0;
      ev_vld_q  <= 1'b0;
      rp_vld_q  <= '0;
      rf_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      dp_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      in_vld_q  <= s_axis_tvalid;
      lp_vld_q  <= {lp_vld_q[LANE_LAT-2:0], in_vld_q};
      mg_vld_q  <= lp_vld_q[LANE_LAT-1];
      ev_vld_q  <= mg_vld_q;
      rp_vld_q  <= {rp_vld_q[MUL_LAT-2:0], ev_vld_q};
      rf_vld_q  <= rp_vld_q[MUL_LAT-1];
      sq_vld_q  <= {sq_vld_q[SQ_LAT-2:0], rf_vld_q};
      dp_vld_q  <= sq_vld_q[SQ_LAT-1];
      dv_vld_q  <= {dv_vld_q[DV_LAT-2:0], dp_vld_q};
      out_vld_q <= dv_vld_q[DV_LAT-1];
    end
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    v3alu_lane #(.W(W), .F(F), .IDX(i)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .func_i(in_q.func),
      .a_i   (in_q.a),
      .b_i   (in_q.b),
      .s_i   (in_q.s),
      .v_o   (lane_v[i])
    );

    v3alu_mul #(.AW(W + 1), .BW(W)) u_rmul (
      .clk_i(clk_i),
      .en_i (en),
      .a_i  ($signed(ev_q.dt2)),
      .b_i  ($signed(ev_q.b[i])),
      .p_o  (rp_p[i])
    );

    v3alu_div #(.NW(W + F), .DW(W)) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(num_q[i]),
      .den_i(den_q),
      .quo_o(quo[i])
    );
  end

  v3alu_sqrt #(.RB(W + 1)) u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .rad_i (rf_q.rad),
    .root_o(root)
  );

  // add, sub, products, dot and squared length; prepare reflect and root
  always_comb begin
    ev_d     = mg_q;
    ev_d.sat = 1'b0;
    sum_s    = sat_f(SW'(sum_q >>> F));
    ea       = '0;
    eb       = '0;
    rv       = '0;
    for (int i = 0; i < 3; i++) begin
      ea = SW'($signed(mg_q.a[i]));
      eb = SW'($signed(mg_q.b[i]));
      case (mg_q.func)
        FN_ADD:                      rv = sat_f(ea + eb);
        FN_SUB:                      rv = sat_f(ea - eb);
        FN_SCALE, FN_CROSS, FN_LERP: rv = sat_f(SW'(vm_q[i] >>> F));
        default:                     rv = '0;
      endcase
      ev_d.r[i] = rv[W-1:0];
      ev_d.sat  = ev_d.sat | rv[W];
    end
    ev_d.sc  = '0;
    ev_d.rad = '0;
    ev_d.dt2 = {sum_s[W-1:0], 1'b0};
    case (mg_q.func)
      FN_LENSQ, FN_DOT: begin
        ev_d.sc  = sum_s[W-1:0];
        ev_d.sat = ev_d.sat | sum_s[W];
      end
      FN_REFLECT: begin
        ev_d.sat = ev_d.sat | sum_s[W];
      end
      FN_LEN, FN_NORM, FN_DIST: begin
        ev_d.rad = sum_q[2*W+1:0];
      end
      default: begin
        ev_d.rad = '0;
      end
    endcase
  end

  // reflect: a - floor(2*d*n / unit)
  always_comb begin
    rf_d  = rp_q[MUL_LAT-1];
    rv_rf = '0;
    for (int i = 0; i < 3; i++) begin
      rv_rf = sat_f(SW'($signed(rp_q[MUL_LAT-1].a[i])) - SW'(rp_p[i] >>> F));
      if (rp_q[MUL_LAT-1].func == FN_REFLECT) begin
        rf_d.r[i] = rv_rf[W-1:0];
        rf_d.sat  = rf_d.sat | rv_rf[W];
      end
    end
  end

  // lengths and divider operands
  always_comb begin
    dp_d   = sq_q[SQ_LAT-1];
    root_s = sat_f(SW'(root));
    den_d  = '0;
    case (sq_q[SQ_LAT-1].func)
      FN_LEN, FN_DIST: begin
        dp_d.sc  = root_s[W-1:0];
        dp_d.sat = dp_d.sat | root_s[W];
      end
      FN_NORM: begin
        den_d   = root[W-1:0];
        dp_d.dz = root == '0;
      end
      FN_DIV: begin
        den_d   = mag_f(sq_q[SQ_LAT-1].s);
        dp_d.dz = sq_q[SQ_LAT-1].s == '0;
      end
      default: begin
        den_d = '0;
      end
    endcase
    for (int i = 0; i < 3; i++) begin
      num_d[i]    = {mag_f(sq_q[SQ_LAT-1].a[i]), {F{1'b0}}};
      dp_d.neg[i] = sq_q[SQ_LAT-1].a[i][W-1]
                  ^ ((sq_q[SQ_LAT-1].func == FN_DIV) & sq_q[SQ_LAT-1].s[W-1]);
    end
  end

  // signed quotients for divide and normalize
  always_comb begin
    out_d = dv_q[DV_LAT-1];
    qe    = '0;
    rv_q  = '0;
    for (int i = 0; i < 3; i++) begin
      qe   = SW'(quo[i]);
      rv_q = sat_f(dv_q[DV_LAT-1].neg[i] ? -qe : qe);
      if ((dv_q[DV_LAT-1].func == FN_DIV || dv_q[DV_LAT-1].func == FN_NORM)
          && !dv_q[DV_LAT-1].dz) begin
        out_d.r[i] = rv_q[W-1:0];
        out_d.sat  = out_d.sat | rv_q[W];
      end
    end
  end

  // payload; advance only when the output slot frees up
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q     <= in_d;
      lp_q[0]  <= in_q;
      for (int k = 1; k < LANE_LAT; k++) begin
        lp_q[k] <= lp_q[k-1];
      end
      mg_q     <= lp_q[LANE_LAT-1];
      sum_q    <= (2*W+5)'(lane_v[0]) + (2*W+5)'(lane_v[1]) + (2*W+5)'(lane_v[2]);
      for (int i = 0; i < LANES; i++) begin
        vm_q[i]  <= lane_v[i];
        num_q[i] <= num_d[i];
      end
      ev_q     <= ev_d;
      rp_q[0]  <= ev_q;
      for (int k = 1; k < MUL_LAT; k++) begin
        rp_q[k] <= rp_q[k-1];
      end
      rf_q     <= rf_d;
      sq_q[0]  <= rf_q;
      for (int k = 1; k < SQ_LAT; k++) begin
        sq_q[k] <= sq_q[k-1];
      end
      dp_q     <= dp_d;
      den_q    <= den_d;
      dv_q[0]  <= dp_q;
      for (int k = 1; k < DV_LAT; k++) begin
        dv_q[k] <= dv_q[k-1];
      end
      out_q    <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DW'({out_q.sc, out_q.r[2], out_q.r[1], out_q.r[0]});
  assign m_axis_tuser  = {out_q.sat, out_q.dz};

  `V3_ASSERT(a_dz_zero, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
  `V3_ASSERT(a_unknown_zero, out_vld_q && (4'(out_q.func) > 4'(FN_LERP)) |-> m_axis_tdata == '0 && m_axis_tuser == 2'b00)
  `V3_ASSERT(a_scalar_novec, out_vld_q && (out_q.func == FN_LEN || out_q.func == FN_LENSQ || out_q.func == FN_DOT || out_q.func == FN_DIST) |-> out_q.r == '0)
  `V3_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> !m_axis_tvalid)

endmodule

/* hdl/v3alu_mul.sv */
// Two-stage signed multiplier built from two half-width partial products.
module v3alu_mul #(
  parameter int unsigned AW = 33,
  parameter int unsigned BW = 33
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [AW-1:0]     a_i,
  input  logic signed [BW-1:0]     b_i,
  output logic signed [AW+BW-1:0]  p_o
);

  localparam int unsigned LB = BW / 2;
  localparam int unsigned HB = BW - LB;

  logic signed [LB:0]       b_lo;
  logic signed [HB-1:0]     b_hi;
  logic signed [AW+LB:0]    lo_q;
  logic signed [AW+HB-1:0]  hi_q;
  logic signed [AW+BW-1:0]  p_q;

  assign b_lo = $signed({1'b0, b_i[LB-1:0]});
  assign b_hi = b_i[BW-1:LB];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= a_i * b_lo;
      hi_q <= a_i * b_hi;
      p_q  <= $signed({hi_q, {LB{1'b0}}}) + (AW+BW)'(lo_q);
    end
  end

  assign p_o = p_q;

endmodule

/* hdl/v3alu_lane.sv */
// One component lane: operand selection, two multipliers and their sum or difference.
module v3alu_lane import v3alu_pkg::*; #(
  parameter int unsigned W   = 32,
  parameter int unsigned F   = 16,
  parameter int unsigned IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  func_e                 func_i,
  input  logic [2:0][W-1:0]     a_i,
  input  logic [2:0][W-1:0]     b_i,
  input  logic [W-1:0]          s_i,
  output logic signed [2*W+2:0] v_o
);

  localparam int unsigned J  = (IDX + 1) % 3;
  localparam int unsigned K  = (IDX + 2) % 3;
  localparam int unsigned OW = W + 1;
  localparam logic signed [OW-1:0] UNIT = OW'(1) << F;

  function automatic logic signed [OW-1:0] ext(input logic [W-1:0] v);
    return $signed({v[W-1], v});
  endfunction

  logic signed [OW-1:0]   x0_d, y0_d, x1_d, y1_d;
  logic signed [OW-1:0]   x0_q, y0_q, x1_q, y1_q;
  logic signed [OW-1:0]   dif;
  logic                   sub_d;
  logic [MUL_LAT:0]       sub_q;
  logic signed [2*OW-1:0] p0, p1;
  logic signed [2*W+2:0]  v_q;

  always_comb begin
    dif  = ext(a_i[IDX]) - ext(b_i[IDX]);
    x0_d = '0;
    y0_d = '0;
    x1_d = '0;
    y1_d = '0;
    sub_d = 1'b0;
    case (func_i)
      FN_SCALE: begin
        x0_d = ext(a_i[IDX]);
        y0_d = ext(s_i);
      end
      FN_LEN, FN_LENSQ, FN_NORM: begin
        x0_d = ext(a_i[IDX]);
        y0_d = ext(a_i[IDX]);
      end
      FN_DOT, FN_REFLECT: begin
        x0_d = ext(a_i[IDX]);
        y0_d = ext(b_i[IDX]);
      end
      FN_DIST: begin
        x0_d = dif;
        y0_d = dif;
      end
      FN_CROSS: begin
        x0_d  = ext(a_i[J]);
        y0_d  = ext(b_i[K]);
        x1_d  = ext(a_i[K]);
        y1_d  = ext(b_i[J]);
        sub_d = 1'b1;
      end
      FN_LERP: begin
        x0_d = ext(a_i[IDX]);
        y0_d = UNIT - ext(s_i);
        x1_d = ext(b_i[IDX]);
        y1_d = ext(s_i);
      end
      default: begin
        x0_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q  <= x0_d;
      y0_q  <= y0_d;
      x1_q  <= x1_d;
      y1_q  <= y1_d;
      sub_q <= {sub_q[MUL_LAT-1:0], sub_d};
      v_q   <= sub_q[MUL_LAT] ? (2*W+3)'(p0) - (2*W+3)'(p1)
                              : (2*W+3)'(p0) + (2*W+3)'(p1);
    end
  end

  v3alu_mul #(.AW(OW), .BW(OW)) u_mul0 (
    .clk_i(clk_i), .en_i(en_i), .a_i(x0_q), .b_i(y0_q), .p_o(p0)
  );

  v3alu_mul #(.AW(OW), .BW(OW)) u_mul1 (
    .clk_i(clk_i), .en_i(en_i), .a_i(x1_q), .b_i(y1_q), .p_o(p1)
  );

  assign v_o = v_q;

endmodule

/* hdl/v3alu_sqrt.sv */
// Pipelined floor square root, one result bit per stage.
module v3alu_sqrt #(
  parameter int unsigned RB = 33
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RB-1:0] rad_i,
  output logic [RB-1:0]   root_o
);

  localparam int unsigned XW = 2 * RB;
  localparam int unsigned RW = RB + 2;

  logic [XW-1:0] x_q   [RB-1];
  logic [RW-1:0] rem_q [RB-1];
  logic [RB-1:0] rt_q  [RB];

  for (genvar k = 0; k < RB; k++) begin : g_stage
    logic [XW-1:0] x_in;
    logic [RW-1:0] rem_in;
    logic [RB-1:0] rt_in;
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign x_in   = rad_i;
      assign rem_in = '0;
      assign rt_in  = '0;
    end else begin : g_next
      assign x_in   = x_q[k-1];
      assign rem_in = rem_q[k-1];
      assign rt_in  = rt_q[k-1];
    end

    // bring down the next two radicand bits and try root bit one
    assign cur   = {rem_in, x_in[XW-1 -: 2]};
    assign trial = (RW+2)'({rt_in, 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rt_q[k] <= {rt_in[RB-2:0], ge};
      end
    end

    if (k < RB - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[k]   <= x_in << 2;
          rem_q[k] <= ge ? RW'(cur - trial) : RW'(cur);
        end
      end
    end
  end

  assign root_o = rt_q[RB-1];

endmodule

/* hdl/v3alu_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage.
module v3alu_div #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [NW-1:0] n_q   [NW-1];
  logic [DW-1:0] rem_q [NW-1];
  logic [DW-1:0] den_q [NW-1];
  logic [NW-1:0] qt_q  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] n_in;
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [NW-1:0] qt_in;
    logic [DW:0]   cur;
    logic          ge;

    if (k == 0) begin : g_first
      assign n_in   = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
      assign qt_in  = '0;
    end else begin : g_next
      assign n_in   = n_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign qt_in  = qt_q[k-1];
    end

    assign cur = {rem_in, n_in[NW-1]};
    assign ge  = cur >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        qt_q[k] <= {qt_in[NW-2:0], ge};
      end
    end

    if (k < NW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          n_q[k]   <= n_in << 1;
          rem_q[k] <= ge ? DW'(cur - {1'b0, den_in}) : DW'(cur);
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quo_o = qt_q[NW-1];

endmodule

/* tb/vec3_alu_checker.sv */
`timescale 1ns / 1ps
// Checker for the vector ALU: predicts every accepted beat and compares the output stream.
module vec3_alu_checker import v3alu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [223:0] s_axis_tdata,
  input  logic [3:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [127:0] m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           errors_o,
  output int           pending_o,
  output int           results_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [31:0] rx;
    logic [31:0] ry;
    logic [31:0] rz;
    logic [31:0] scalar_out;
    logic        div_zero;
    logic        saturated;
  } vec_result_t;

  localparam wide_t MAXW = 2147483647;
  localparam wide_t MINW = -MAXW - 1;
  localparam wide_t UNIT = 65536;

  vec_result_t expected_q[$];
  int errors = 0;
  int results = 0;

  function automatic logic [31:0] clamp_word(input wide_t v, inout bit sat);
    if (v < MINW) begin
      sat = 1'b1;
      return MINW[31:0];
    end
    if (v > MAXW) begin
      sat = 1'b1;
      return MAXW[31:0];
    end
    return v[31:0];
  endfunction

  // floor root of a non-negative value below 2^127
  function automatic logic [63:0] floor_root(input wide_t x);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= x) r = c;
    end
    return r;
  endfunction

  function automatic vec_result_t compute_vector_op(input logic [3:0] fn,
                                                    input logic [223:0] d);
    vec_result_t res;
    wide_t       a[3];
    wide_t       b[3];
    wide_t       s;
    wide_t       acc;
    wide_t       dt;
    wide_t       dv;
    logic [31:0] r[3];
    logic [31:0] sc;
    logic [63:0] len;
    bit          sat;
    bit          dz;
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'($signed(d[32*i +: 32]));
      b[i] = wide_t'($signed(d[32*(i+3) +: 32]));
      r[i] = '0;
    end
    s = wide_t'($signed(d[192 +: 32]));
    sc = '0;
    sat = 1'b0;
    dz = 1'b0;
    case (fn)
      FN_ADD: for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] + b[i], sat);
      FN_SUB: for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - b[i], sat);
      FN_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp_word((a[i] * s) >>> 16, sat);
      FN_DIV: begin
        if (s == 0) dz = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = clamp_word((a[i] * UNIT) / s, sat);
      end
      FN_LEN: sc = clamp_word(wide_t'(floor_root(a[0]*a[0] + a[1]*a[1] + a[2]*a[2])), sat);
      FN_LENSQ: sc = clamp_word((a[0]*a[0] + a[1]*a[1] + a[2]*a[2]) >>> 16, sat);
      FN_NORM: begin
        len = floor_root(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
        if (len == 0) dz = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = clamp_word((a[i] * UNIT) / wide_t'(len), sat);
      end
      FN_DOT: sc = clamp_word((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> 16, sat);
      FN_DIST: begin
        acc = 0;
        for (int i = 0; i < 3; i++) begin
          dv = a[i] - b[i];
          acc = acc + dv * dv;
        end
        sc = clamp_word(wide_t'(floor_root(acc)), sat);
      end
      FN_CROSS: begin
        r[0] = clamp_word((a[1]*b[2] - a[2]*b[1]) >>> 16, sat);
        r[1] = clamp_word((a[2]*b[0] - a[0]*b[2]) >>> 16, sat);
        r[2] = clamp_word((a[0]*b[1] - a[1]*b[0]) >>> 16, sat);
      end
      FN_REFLECT: begin
        // clamp the dot to a word before scaling the normal
        dt = wide_t'($signed(clamp_word((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> 16, sat)));
        for (int i = 0; i < 3; i++)
          r[i] = clamp_word(a[i] - (((dt * 2) * b[i]) >>> 16), sat);
      end
      FN_LERP: for (int i = 0; i < 3; i++)
        r[i] = clamp_word((a[i] * (UNIT - s) + b[i] * s) >>> 16, sat);
      default: ;
    endcase
    res.rx = r[0];
    res.ry = r[1];
    res.rz = r[2];
    res.scalar_out = sc;
    res.div_zero = dz;
    res.saturated = sat;
    return res;
  endfunction

  always @(posedge clk_i) begin
    vec_result_t want;
    vec_result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(compute_vector_op(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        results++;
        got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
               m_axis_tdata[127:96], m_axis_tuser[0], m_axis_tuser[1]};
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.rx !== want.rx) begin
            $error("rx: expected %h, actual %h", want.rx, got.rx);
            errors++;
          end
          if (got.ry !== want.ry) begin
            $error("ry: expected %h, actual %h", want.ry, got.ry);
            errors++;
          end
          if (got.rz !== want.rz) begin
            $error("rz: expected %h, actual %h", want.rz, got.rz);
            errors++;
          end
          if (got.scalar_out !== want.scalar_out) begin
            $error("scalar_out: expected %h, actual %h", want.scalar_out, got.scalar_out);
            errors++;
          end
          if (got.div_zero !== want.div_zero) begin
            $error("div_zero: expected %b, actual %b", want.div_zero, got.div_zero);
            errors++;
          end
          if (got.saturated !== want.saturated) begin
            $error("saturated: expected %b, actual %b", want.saturated, got.saturated);
            errors++;
          end
        end
      end
    end
  end

  assign errors_o = errors;
  assign pending_o = expected_q.size();
  assign results_o = results;

endmodule

/* tb/tb_vec3_fixed_point_alu_core.sv */
`timescale 1ns / 1ps
// Testbench top for the vector ALU: clock, reset, stimulus and verdict.
module tb_vec3_fixed_point_alu_core;
  import v3alu_pkg::*;

  localparam logic [31:0] WMAX = 32'h7fffffff;
  localparam logic [31:0] WMIN = 32'h80000000;
  localparam logic [31:0] ONE  = 32'h00010000;
  localparam int          RANDOM_ITEMS = 1330;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // ax, ay, az, bx, by, bz, scalar_in (lowest first)
  logic [223:0] s_axis_tdata = '0;
  // func
  logic [3:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // rx, ry, rz, scalar_out (lowest first)
  logic [127:0] m_axis_tdata;
  // div_zero, saturated (lowest first)
  logic [1:0]   m_axis_tuser;

  int errors;
  int pending;
  int results;
  int beats_sent = 0;
  int stall_left = 0;
  bit stall_on = 1'b1;

  always #4 clk_i = ~clk_i;

  vec3_fixed_point_alu_core dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  vec3_alu_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // output stall: mostly short, some long, with stall-free stretches
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 299) == 0) stall_on <= ~stall_on;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4:    return $urandom_range(0, 32'h000fffff) - 32'h00080000;
      5:       return 32'h0;
      6:       return WMAX;
      7:       return WMIN;
      8:       return ($urandom_range(0, 8) - 4) << 16;
      default: return $urandom_range(0, 32'h0fffffff) - 32'h08000000;
    endcase
  endfunction

  task automatic send_vector_op(input logic [3:0] fn,
                                input logic [31:0] ax, input logic [31:0] ay,
                                input logic [31:0] az, input logic [31:0] bx,
                                input logic [31:0] by, input logic [31:0] bz,
                                input logic [31:0] sv);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {sv, bz, by, bx, az, ay, ax};
    forever begin
      @(negedge clk_i);
      if (s_axis_tready) break;
    end
    @(posedge clk_i);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [3:0]  fn;
    logic [31:0] w[7];
    int          waited;
    // assert reset with an edge so the block clears before the first clock
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_vector_op(FN_ADD, WMAX, WMIN, ONE, WMAX, WMIN, 32'hffffffff, 0);
    send_vector_op(FN_SUB, WMIN, WMAX, 0, WMAX, WMIN, 0, 0);
    send_vector_op(FN_SCALE, WMAX, WMIN, 32'h00018000, WMAX, 0, 0, WMIN);
    send_vector_op(FN_SCALE, 32'hffff8000, ONE, 32'h3, 0, 0, 0, 32'h00008000);
    send_vector_op(FN_DIV, WMAX, WMIN, 32'hfffe8000, 0, 0, 0, 32'h1);
    send_vector_op(FN_DIV, ONE, 32'h5, 32'hfffffffb, 0, 0, 0, 32'hfffd0000);
    send_vector_op(FN_DIV, ONE, ONE, ONE, 0, 0, 0, 0);
    send_vector_op(FN_LEN, WMIN, WMIN, WMIN, 0, 0, 0, 0);
    send_vector_op(FN_LEN, 32'h00030000, 32'h00040000, 0, 0, 0, 0, 0);
    send_vector_op(FN_LENSQ, WMAX, WMAX, WMAX, 0, 0, 0, 0);
    send_vector_op(FN_NORM, 0, 0, 0, ONE, ONE, ONE, ONE);
    send_vector_op(FN_NORM, 32'h1, 0, 0, 0, 0, 0, 0);
    send_vector_op(FN_NORM, WMIN, WMAX, 32'h00030000, 0, 0, 0, 0);
    send_vector_op(FN_DOT, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 0);
    send_vector_op(FN_DOT, 32'hfffffff1, ONE, 0, 32'h7, 32'hffff0000, 0, 0);
    send_vector_op(FN_DIST, WMAX, WMAX, WMAX, WMIN, WMIN, WMIN, 0);
    send_vector_op(FN_CROSS, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0);
    send_vector_op(FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
    // dot far outside the word: the clamp also flags saturation
    send_vector_op(FN_REFLECT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0);
    send_vector_op(FN_REFLECT, ONE, 32'hffff0000, 0, 0, ONE, 0, 0);
    send_vector_op(FN_LERP, WMIN, WMAX, 0, WMAX, WMIN, ONE, 32'h00008000);
    send_vector_op(FN_LERP, ONE, ONE, ONE, WMAX, WMAX, WMAX, WMIN);
    send_vector_op(FN_LERP, 32'h5, 32'hfffffff3, 0, 32'h9, 0, 0, WMAX);
    for (int c = 12; c < 16; c++)
      send_vector_op(4'(c), WMAX, WMIN, 32'hffffffff, WMAX, WMIN, 32'hffffffff, WMIN);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      fn = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                        : 4'($urandom_range(0, 11));
      foreach (w[k]) w[k] = pick_word();
      if (fn == FN_NORM && $urandom_range(0, 9) == 0) begin
        w[0] = 0;
        w[1] = 0;
        w[2] = 0;
      end
      send_vector_op(fn, w[0], w[1], w[2], w[3], w[4], w[5], w[6]);
    end
    s_axis_tvalid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (150) @(posedge clk_i);

    $display("sent %0d beats over all operation codes, checked %0d result beats",
             beats_sent, results);
    $display("with random gaps on input and random stalls on output");
    if (errors == 0 && pending == 0) begin
      $display("tb_vec3_fixed_point_alu_core passed");
    end else begin
      if (pending != 0) $error("%0d expected results never arrived", pending);
      $display("tb_vec3_fixed_point_alu_core failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("timeout after %0d beats sent", beats_sent);
    $display("tb_vec3_fixed_point_alu_core failed");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/v3alu_pkg.sv
hdl/v3alu_mul.sv
hdl/v3alu_lane.sv
hdl/v3alu_sqrt.sv
hdl/v3alu_div.sv
hdl/vec3_fixed_point_alu_core.sv
tb/vec3_alu_checker.sv
tb/tb_vec3_fixed_point_alu_core.sv
